[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants for the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MaxBlocks   = 64;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = IdxW + 1;
  localparam int HeaderBytes = 24;
  localparam int OffW        = 20;
  localparam int SizeW       = 21;
  localparam int AddrW       = 32;

  localparam logic [31:0] HeapBaseReset  = 32'h0030_0000;
  localparam logic [20:0] HeapBytesReset = 21'h10_0000;
  localparam logic [20:0] HeapBytesMin   = 21'd64;
  localparam logic [20:0] HeapBytesMax   = 21'h10_0000;
  localparam logic [20:0] AlignMask      = 21'd15;
  localparam logic [21:0] MinSplit       = 22'd16;

  localparam logic [1:0] ModeAlloc = 2'd0;
  localparam logic [1:0] ModeFree  = 2'd1;
  localparam logic [1:0] ModeInit  = 2'd2;

  localparam logic [1:0] StatDone   = 2'd0;
  localparam logic [1:0] StatNoFit  = 2'd1;
  localparam logic [1:0] StatIgnore = 2'd2;

  localparam logic [0:0] RegHeapBase  = 1'd0;
  localparam logic [0:0] RegHeapBytes = 1'd1;

  // descriptor word: {free, size, offset}
  localparam int DescW = 1 + SizeW + OffW;

  typedef struct packed {
    logic            is_free;
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  offset;
  } desc_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // latch item, compute need
    CMD_INIT,      // rebuild table
    CMD_RD,        // issue read of index ptr
    CMD_EVAL,      // evaluate read data at ptr
    CMD_SHIFT_UP,  // write mem[ptr] = cur (read at ptr-1), ptr--
    CMD_SHIFT_DN,  // write mem[ptr] = read(ptr+1), ptr++
    CMD_WR_SPLIT,  // write new split pieces
    CMD_WR_HIT,    // write hit entry
    CMD_MERGE,     // misc merge steps
    CMD_SUM,       // recount accumulate
    CMD_RESULT     // drive result
  } cmd_e;

  typedef struct packed {
    cmd_e           cmd;
    logic [IdxW-1:0] ptr;
    logic [2:0]      sub;
  } ctl_t;

  typedef struct packed {
    logic            hit;       // eval: entry matches
    logic            can_split;
    logic            prev_free;
    logic            next_free;
    logic            is_free;
    logic            zero_req;
    logic [CntW-1:0] count;
    logic [1:0]      mode;
  } sts_t;

endpackage

[rtl/ffha_ram.sv]
// ----------------------------------------------------------------------------
// ffha_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/ffha_dp.sv]
// ----------------------------------------------------------------------------
// ffha_dp
// datapath: descriptor ram, totals, item registers and result
// ----------------------------------------------------------------------------
module ffha_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffha_pkg::ctl_t             ctl_i,
  output ffha_pkg::sts_t             sts_o,
  input  logic [1:0]                 mode_i,
  input  logic [ffha_pkg::SizeW-1:0] req_i,
  input  logic [ffha_pkg::AddrW-1:0] addr_i,
  input  logic [31:0]                heap_base_i,
  input  logic [20:0]                heap_bytes_i,
  output logic [ffha_pkg::AddrW-1:0] res_addr_o,
  output logic [1:0]                 res_status_o,
  output logic [ffha_pkg::SizeW-1:0] res_used_o,
  output logic [ffha_pkg::SizeW-1:0] res_free_o
);
  localparam int IdxW = ffha_pkg::IdxW;
  localparam int CntW = ffha_pkg::CntW;
  localparam int SW   = ffha_pkg::SizeW;
  localparam int OffW = ffha_pkg::OffW;

  localparam logic [SW-1:0] HeapBytesResetFree =
    ffha_pkg::HeapBytesReset - SW'(ffha_pkg::HeaderBytes);

  logic [1:0]      mode_q;
  logic [21:0]     need_q;
  logic [31:0]     addr_q;
  logic            zero_q;
  logic [CntW-1:0] count_q, count_d;
  logic [SW-1:0]   used_q, used_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [SW-1:0]   free_q, free_d;
  ffha_pkg::desc_t hold_q, hold_d;   // found / working entry
  ffha_pkg::desc_t prev_q, prev_d;   // previous entry during walk
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            prev_free_q, prev_free_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  ffha_pkg::desc_t wdata, rdata;
  logic [ffha_pkg::DescW-1:0] rbits;
  logic [31:0]     paddr;
  logic [21:0]     split_lim;

  ffha_ram #(.Width(ffha_pkg::DescW), .Depth(ffha_pkg::MaxBlocks)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rbits)
  );
  assign rdata = ffha_pkg::desc_t'(rbits);

  assign paddr = heap_base_i + {12'd0, rdata.offset} + 32'(ffha_pkg::HeaderBytes);
  assign split_lim = need_q + 22'(ffha_pkg::HeaderBytes) + ffha_pkg::MinSplit;

  always_comb begin
    sts_o.mode = mode_q;
    sts_o.zero_req = zero_q;
    sts_o.count = count_q;
    sts_o.is_free = rdata.is_free;
    sts_o.prev_free = prev_free_q;
    sts_o.next_free = rdata.is_free;
    sts_o.can_split = ({1'b0, rdata.size} >= split_lim) &&
                      (count_q < CntW'(ffha_pkg::MaxBlocks));
    if (mode_q == ffha_pkg::ModeAlloc) begin
      sts_o.hit = rdata.is_free && ({1'b0, rdata.size} >= need_q);
    end else begin
      sts_o.hit = (paddr == addr_q);
    end
  end

  // ram address and write selection, and next values of the totals and item registers
  always_comb begin
    we = 1'b0;
    waddr = ctl_i.ptr;
    raddr = ctl_i.ptr;
    wdata = rdata;
    count_d = count_q;
    used_d = used_q;
    sum_d = sum_q;
    free_d = free_q;
    hold_d = hold_q;
    prev_d = prev_q;
    hit_idx_d = hit_idx_q;
    prev_free_d = prev_free_q;
    case (ctl_i.cmd)
      ffha_pkg::CMD_LOAD: begin
        sum_d = '0;
      end
      ffha_pkg::CMD_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata.offset = '0;
        wdata.size = (heap_bytes_i > 21'(ffha_pkg::HeaderBytes)) ?
                     heap_bytes_i - 21'(ffha_pkg::HeaderBytes) : '0;
        wdata.is_free = 1'b1;
        count_d = CntW'(1);
        used_d = '0;
      end
      ffha_pkg::CMD_EVAL: begin
        // remember entry; prev tracks entry before it
        prev_d = hold_q;
        prev_free_d = (ctl_i.ptr != '0) && hold_q.is_free;
        hold_d = rdata;
        hit_idx_d = ctl_i.ptr;
      end
      ffha_pkg::CMD_SHIFT_UP: begin
        // rdata holds entry ptr-1, write it at ptr
        we = 1'b1;
        raddr = ctl_i.ptr - IdxW'(2);
      end
      ffha_pkg::CMD_SHIFT_DN: begin
        // rdata holds entry ptr+1, write it at ptr
        we = 1'b1;
        raddr = ctl_i.ptr + IdxW'(2);
      end
      ffha_pkg::CMD_WR_SPLIT: begin
        we = 1'b1;
        waddr = hit_idx_q + IdxW'(1);
        wdata.offset = hold_q.offset + OffW'(ffha_pkg::HeaderBytes) + need_q[19:0];
        wdata.size = hold_q.size - need_q[20:0] - 21'(ffha_pkg::HeaderBytes);
        wdata.is_free = 1'b1;
        hold_d.size = need_q[20:0];
        count_d = count_q + CntW'(1);
      end
      ffha_pkg::CMD_WR_HIT: begin
        we = 1'b1;
        waddr = hit_idx_q;
        wdata = hold_q;
        wdata.is_free = (mode_q != ffha_pkg::ModeAlloc);
        if (mode_q == ffha_pkg::ModeAlloc) begin
          used_d = used_q + hold_q.size;
        end else begin
          used_d = (used_q >= hold_q.size) ? used_q - hold_q.size : '0;
        end
        hold_d.is_free = wdata.is_free;
      end
      ffha_pkg::CMD_MERGE: begin
        // sub 0: absorb successor (rdata) into hold, write at hit
        // sub 1: absorb hold into prev, write at hit-1
        we = 1'b1;
        if (ctl_i.sub == 3'd0) begin
          waddr = hit_idx_q;
          wdata = hold_q;
          wdata.size = hold_q.size + SW'(ffha_pkg::HeaderBytes) + rdata.size;
          hold_d = wdata;
        end else begin
          waddr = hit_idx_q - IdxW'(1);
          wdata = prev_q;
          wdata.size = prev_q.size + SW'(ffha_pkg::HeaderBytes) + hold_q.size;
        end
        count_d = count_q - CntW'(1);
      end
      ffha_pkg::CMD_SUM: begin
        if (rdata.is_free) begin
          sum_d = sum_q + rdata.size;
        end
      end
      ffha_pkg::CMD_RESULT: begin
        free_d = sum_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
      used_q <= '0;
      free_q <= HeapBytesResetFree;
    end else begin
      count_q <= count_d;
      used_q <= used_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    hold_q <= hold_d;
    prev_q <= prev_d;
    hit_idx_q <= hit_idx_d;
    prev_free_q <= prev_free_d;
    if (ctl_i.cmd == ffha_pkg::CMD_LOAD) begin
      mode_q <= mode_i;
      addr_q <= addr_i;
      // null pointer for a free, zero size for an allocate
      zero_q <= (mode_i == ffha_pkg::ModeFree) ? (addr_i == '0) : (req_i == '0);
      need_q <= ({1'b0, req_i} + {1'b0, ffha_pkg::AlignMask}) & ~22'd15;
    end
    if (ctl_i.cmd == ffha_pkg::CMD_RESULT) begin
      res_addr_o <= (ctl_i.sub == 3'd1) ?
        heap_base_i + {12'd0, hold_q.offset} + 32'(ffha_pkg::HeaderBytes) : '0;
      res_status_o <= ctl_i.sub[2] ? ffha_pkg::StatIgnore :
                      ((ctl_i.sub == 3'd2) ? ffha_pkg::StatNoFit : ffha_pkg::StatDone);
      res_used_o <= used_q;
      res_free_o <= sum_q;
    end
  end
endmodule

[rtl/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl
// sequencer: search walk, shifts, merges, recount and output handshake
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           init_req_i,
  output ffha_pkg::ctl_t ctl_o,
  input  ffha_pkg::sts_t sts_i
);
  localparam int IdxW = ffha_pkg::IdxW;

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_DISP, S_SRD, S_SEVAL, S_SPLIT_RD, S_SPLIT_UP, S_SPLIT_WR,
    S_HIT, S_NEXT_RD, S_NEXT_EV, S_SHDN_RD, S_SHDN, S_PREV, S_SUM, S_OUT
  } state_e;

  state_e          state_q;
  logic [IdxW:0]   ptr_q;      // one extra bit to reach count
  logic [2:0]      res_q;      // result kind code for datapath
  logic            merged_q;   // which merge phase is running
  logic            valid_q;
  logic            sum_pend_q;

  assign in_ready_o  = (state_q == S_IDLE) && !valid_q;
  assign out_valid_o = valid_q;

  // result kinds: 0 done, 1 done with address, 2 no fit, 4 ignored
  always_comb begin
    ctl_o.cmd = ffha_pkg::CMD_NONE;
    ctl_o.ptr = ptr_q[IdxW-1:0];
    ctl_o.sub = {2'd0, merged_q};
    case (state_q)
      S_BOOT:     ctl_o.cmd = ffha_pkg::CMD_INIT;
      S_IDLE:     if (in_valid_i && in_ready_o) ctl_o.cmd = ffha_pkg::CMD_LOAD;
      S_DISP:     if (sts_i.mode == ffha_pkg::ModeInit) ctl_o.cmd = ffha_pkg::CMD_INIT;
      S_SEVAL:    ctl_o.cmd = ffha_pkg::CMD_EVAL;
      S_SPLIT_UP: ctl_o.cmd = ffha_pkg::CMD_SHIFT_UP;
      S_SPLIT_WR: ctl_o.cmd = ffha_pkg::CMD_WR_SPLIT;
      S_HIT:      ctl_o.cmd = ffha_pkg::CMD_WR_HIT;
      S_NEXT_EV:  if (sts_i.next_free && ptr_q < sts_i.count)
                    ctl_o.cmd = ffha_pkg::CMD_MERGE;
      S_SHDN:     ctl_o.cmd = ffha_pkg::CMD_SHIFT_DN;
      S_PREV:     begin
        ctl_o.cmd = ffha_pkg::CMD_MERGE;
        ctl_o.sub = 3'd1;
      end
      S_SUM:      if (sum_pend_q) ctl_o.cmd = ffha_pkg::CMD_SUM;
      S_OUT:      begin
        ctl_o.cmd = ffha_pkg::CMD_RESULT;
        ctl_o.sub = res_q;
      end
      default: ;
    endcase
    // shift reads fetch the source entry one step ahead of the write
    if (state_q == S_SPLIT_RD) ctl_o.ptr = ptr_q[IdxW-1:0] - IdxW'(1);
    if (state_q == S_SHDN_RD) ctl_o.ptr = ptr_q[IdxW-1:0] + IdxW'(1);
  end

  // merge bookkeeping: after a successor merge the entries above k+1 shift
  // down; after a predecessor merge the entries above k shift down
  logic          do_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      ptr_q <= '0;
      res_q <= '0;
      merged_q <= 1'b0;
      valid_q <= 1'b0;
      sum_pend_q <= 1'b0;
      do_prev_q <= 1'b0;
    end else begin
      if (valid_q && out_ready_i) valid_q <= 1'b0;
      case (state_q)
        S_BOOT: state_q <= S_IDLE;
        S_IDLE: if (init_req_i) begin
          state_q <= S_BOOT;
        end else if (in_valid_i && in_ready_o) begin
          state_q <= S_DISP;
        end
        S_DISP: begin
          ptr_q <= '0;
          merged_q <= 1'b0;
          do_prev_q <= 1'b0;
          if (sts_i.mode == ffha_pkg::ModeInit) begin
            res_q <= 3'd0;
            state_q <= S_SUM;
            sum_pend_q <= 1'b0;
          end else if (sts_i.mode == ffha_pkg::ModeAlloc && !sts_i.zero_req) begin
            state_q <= S_SRD;
          end else if (sts_i.mode == ffha_pkg::ModeFree && !sts_i.zero_req) begin
            state_q <= S_SRD;
          end else begin
            res_q <= (sts_i.mode == ffha_pkg::ModeAlloc) ? 3'd2 : 3'd4;
            state_q <= S_SUM;
            sum_pend_q <= 1'b0;
          end
        end
        S_SRD: begin
          if (ptr_q == sts_i.count) begin
            res_q <= (sts_i.mode == ffha_pkg::ModeAlloc) ? 3'd2 : 3'd4;
            ptr_q <= '0;
            sum_pend_q <= 1'b0;
            state_q <= S_SUM;
          end else begin
            state_q <= S_SEVAL;
          end
        end
        S_SEVAL: begin
          if (sts_i.hit) begin
            if (sts_i.mode == ffha_pkg::ModeAlloc) begin
              res_q <= 3'd1;
              if (sts_i.can_split) begin
                ptr_q <= sts_i.count;
                state_q <= S_SPLIT_RD;
              end else begin
                state_q <= S_HIT;
              end
            end else if (sts_i.is_free) begin
              res_q <= 3'd4;
              ptr_q <= '0;
              sum_pend_q <= 1'b0;
              state_q <= S_SUM;
            end else begin
              res_q <= 3'd0;
              state_q <= S_HIT;
            end
          end else begin
            ptr_q <= ptr_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_SPLIT_RD: begin
          // shift entries hit+1 .. count-1 up by one, top first
          if (ptr_q == {1'b0, hit_idx_ext()} + 1'b1) begin
            state_q <= S_SPLIT_WR;
          end else begin
            state_q <= S_SPLIT_UP;
          end
        end
        S_SPLIT_UP: begin
          ptr_q <= ptr_q - 1'b1;
          state_q <= S_SPLIT_RD;
        end
        S_SPLIT_WR: state_q <= S_HIT;
        S_HIT: begin
          if (sts_i.mode == ffha_pkg::ModeFree) begin
            // predecessor flag was captured when the hit entry was evaluated
            do_prev_q <= sts_i.prev_free;
            ptr_q <= {1'b0, hit_idx_ext()} + 1'b1;
            state_q <= S_NEXT_RD;
          end else begin
            ptr_q <= '0;
            sum_pend_q <= 1'b0;
            state_q <= S_SUM;
          end
        end
        S_NEXT_RD: state_q <= S_NEXT_EV;
        S_NEXT_EV: begin
          if (sts_i.next_free && ptr_q < sts_i.count) begin
            // successor at ptr removed: shift entries above it down
            state_q <= S_SHDN_RD;
          end else begin
            state_q <= do_prev_q ? S_PREV : S_SUM;
            if (!do_prev_q) begin
              ptr_q <= '0;
              sum_pend_q <= 1'b0;
            end
          end
        end
        S_SHDN_RD: begin
          if (ptr_q >= sts_i.count) begin
            state_q <= do_prev_q ? S_PREV : S_SUM;
            if (!do_prev_q) begin
              ptr_q <= '0;
              sum_pend_q <= 1'b0;
            end
          end else begin
            state_q <= S_SHDN;
          end
        end
        S_SHDN: begin
          ptr_q <= ptr_q + 1'b1;
          state_q <= S_SHDN_RD;
        end
        S_PREV: begin
          merged_q <= 1'b1;
          ptr_q <= {1'b0, hit_idx_ext()};
          do_prev_q <= 1'b0;
          state_q <= S_SHDN_RD;
        end
        S_SUM: begin
          // registered read: pend marks valid data at ptr-1
          if (ptr_q == sts_i.count) begin
            if (sum_pend_q) begin
              sum_pend_q <= 1'b0;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            ptr_q <= ptr_q + 1'b1;
            sum_pend_q <= 1'b1;
          end
        end
        S_OUT: begin
          valid_q <= 1'b1;
          merged_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // hit index mirrored locally from the walk pointer at evaluation
  logic [IdxW-1:0] hit_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_SEVAL) hit_q <= ptr_q[IdxW-1:0];
  end
  function automatic logic [IdxW-1:0] hit_idx_ext();
    return hit_q;
  endfunction

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !valid_q)
    else $error("item taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> valid_q)
    else $error("result not posted");
endmodule

[rtl/first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// first-fit heap allocator over an address-ordered descriptor table
// ----------------------------------------------------------------------------
// channel  | dir | ports                 | beat contents
// s_axis   | in  | tvalid/tready/tdata   | mode, request_size, block_address
// m_axis   | out | tvalid/tready/tdata   | result_address, status, used, free
// apb      | in  | psel/penable/...      | heap_base @0x0, heap_bytes @0x4
//
// one item at a time; the search walk reads entries in address order, a
// table shift moves entries one at a time (one shift for a split, up to two for
// a free that merges both neighbors) and the free-byte recount reads every
// entry, all through the single read port of the descriptor ram
// reset loads the default heap (entry zero only)
// a finished result holds on m_axis until taken; no new beat is accepted
// until then
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] mode, [22:2] request_size, [54:23] block_address, zero fill
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result_address, [33:32] status, [54:34] used, [75:55] free
  output logic [79:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] heap_base_q;
  logic [20:0] heap_bytes_q;
  logic [20:0] wclamp;
  logic [31:0] res_addr;
  logic [1:0]  res_status;
  logic [20:0] res_used, res_free;
  ffha_pkg::ctl_t ctl;
  ffha_pkg::sts_t sts;

  assign pready = 1'b1;
  // clamp heap size writes into the supported range
  assign wclamp = (pwdata[20:0] < ffha_pkg::HeapBytesMin) ? ffha_pkg::HeapBytesMin :
                  (pwdata[20:0] > ffha_pkg::HeapBytesMax) ? ffha_pkg::HeapBytesMax :
                  pwdata[20:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= ffha_pkg::HeapBaseReset;
      heap_bytes_q <= ffha_pkg::HeapBytesReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2] == ffha_pkg::RegHeapBase) heap_base_q <= pwdata;
      else heap_bytes_q <= wclamp;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ffha_pkg::RegHeapBase) prdata = heap_base_q;
    else prdata = {11'd0, heap_bytes_q};
  end

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .init_req_i  (1'b0),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  ffha_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .mode_i       (s_axis_tdata[1:0]),
    .req_i        (s_axis_tdata[22:2]),
    .addr_i       (s_axis_tdata[54:23]),
    .heap_base_i  (heap_base_q),
    .heap_bytes_i (heap_bytes_q),
    .res_addr_o   (res_addr),
    .res_status_o (res_status),
    .res_used_o   (res_used),
    .res_free_o   (res_free)
  );

  assign m_axis_tdata = {4'd0, res_free, res_used, res_status, res_addr};
endmodule
